/* rtl/sla_pkg.sv */
package sla_pkg;

  localparam int LEN_W    = 32;
  localparam int SEG_W    = 31;
  localparam int SHIFT_W  = 5;
  localparam int TOTAL_W  = 38;
  localparam int ID_W     = 48;
  localparam int OFF_W    = 30;
  localparam int CNT_W    = 11;  // holds a batch count up to the largest batch size
  localparam int ENTRY_W  = 1 + LEN_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT   = 2'd1;

  localparam logic [SEG_W-1:0]   SEGMENT_BYTES_RST = 31'd4194304;
  localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST   = 5'd12;

  localparam logic [ID_W-1:0]    ID_MAX    = {ID_W{1'b1}};
  localparam logic [SEG_W-1:0]   USED_MAX  = {SEG_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // one closed batch handed from the front to the back
  typedef struct packed {
    logic               bank;
    logic [CNT_W-1:0]   count;
    logic [TOTAL_W-1:0] total;
  } batch_desc_t;

  // buffer entry: last flag, raw length
  typedef struct packed {
    logic             last;
    logic [LEN_W-1:0] len;
  } batch_entry_t;

endpackage

/* rtl/sla_front.sv */
module sla_front
  import sla_pkg::*;
#(
  parameter int MAX_BATCH = 64,
  localparam int IW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1,
  localparam int AW = IW + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [SEG_W-1:0]    segment_bytes,
  input  logic [SHIFT_W-1:0]  block_shift,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [LEN_W-1:0]    in_len,
  input  logic                in_last,
  output logic                desc_push,
  output batch_desc_t         desc,
  input  logic                release_valid,
  input  logic                release_bank,
  input  logic [AW-1:0]       rd_addr,
  output batch_entry_t        rd_data
);

  localparam int CW = $clog2(MAX_BATCH + 1);
  localparam logic [CW-1:0] LAST_FILL = CW'(MAX_BATCH - 1);

  batch_entry_t mem [2**AW];

  logic [1:0]       busy;
  logic [1:0]       busy_next;
  logic             wbank;
  logic [CW-1:0]    fill;

  // stage B registers
  logic             b_valid;
  logic [AW-1:0]    b_addr;
  batch_entry_t     b_entry;
  logic [LEN_W-1:0] b_aligned;
  logic             b_close;
  logic [CW-1:0]    b_count;
  logic             b_bank;
  logic [TOTAL_W-1:0] total;

  logic             accept;
  logic             close;
  logic [LEN_W:0]   bs;
  logic [LEN_W-1:0] mask;
  logic [LEN_W:0]   rnd_sum;
  logic [LEN_W-1:0] aligned;
  logic [TOTAL_W:0] tsum;
  logic [TOTAL_W-1:0] tsat;

  assign in_ready = !busy[wbank];
  assign accept   = in_valid && in_ready;
  assign close    = in_last || (fill == LAST_FILL);

  always_comb begin
    bs      = (LEN_W+1)'(1) << block_shift;
    mask    = LEN_W'(bs - (LEN_W+1)'(1));
    rnd_sum = {1'b0, in_len} + {1'b0, mask};
    if (in_len == '0) begin
      aligned = '0;
    end else if ({1'b0, in_len} >= {2'b0, segment_bytes}) begin
      aligned = {1'b0, segment_bytes};
    end else begin
      aligned = rnd_sum[LEN_W-1:0] & ~mask;
    end
  end

  always_comb begin
    tsum = {1'b0, total} + (TOTAL_W+1)'(b_aligned);
    tsat = tsum[TOTAL_W] ? TOTAL_MAX : tsum[TOTAL_W-1:0];
  end

  always_comb begin
    busy_next = busy;
    if (accept && close) begin
      busy_next[wbank] = 1'b1;
    end
    if (release_valid) begin
      busy_next[release_bank] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= '0;
      wbank   <= 1'b0;
      fill    <= '0;
      b_valid <= 1'b0;
      total   <= '0;
    end else begin
      b_valid <= accept;
      busy    <= busy_next;
      if (accept) begin
        if (close) begin
          fill  <= '0;
          wbank <= !wbank;
        end else begin
          fill <= fill + CW'(1);
        end
      end
      if (b_valid) begin
        total <= b_close ? '0 : tsat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_addr    <= {wbank, fill[IW-1:0]};
      b_entry   <= '{last: in_last, len: in_len};
      b_aligned <= aligned;
      b_close   <= close;
      b_count   <= fill + CW'(1);
      b_bank    <= wbank;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      mem[b_addr] <= b_entry;
    end
    rd_data <= mem[rd_addr];
  end

  assign desc_push  = b_valid && b_close;
  assign desc.bank  = b_bank;
  assign desc.count = CNT_W'(b_count);
  assign desc.total = tsat;

endmodule

/* rtl/sla_queue.sv */
module sla_queue
  import sla_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  batch_desc_t push_desc,
  input  logic        pop,
  output logic        nonempty,
  output batch_desc_t head
);

  batch_desc_t slot [2];
  logic        rptr;
  logic        wptr;
  logic [1:0]  count;

  assign nonempty = (count != 2'd0);
  assign head     = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr  <= 1'b0;
      wptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && count != 2'd2) begin
        wptr <= !wptr;
      end
      if (pop && nonempty) begin
        rptr <= !rptr;
      end
      case ({push && count != 2'd2, pop && nonempty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && count != 2'd2) begin
      slot[wptr] <= push_desc;
    end
  end

endmodule

/* rtl/sla_back.sv */
module sla_back
  import sla_pkg::*;
#(
  parameter int MAX_BATCH = 64,
  localparam int IW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1,
  localparam int AW = IW + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [SEG_W-1:0]   segment_bytes,
  input  logic [SHIFT_W-1:0] block_shift,
  input  logic               desc_valid,
  input  batch_desc_t        desc,
  output logic               desc_pop,
  output logic               release_valid,
  output logic               release_bank,
  output logic [AW-1:0]      rd_addr,
  input  batch_entry_t       rd_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ID_W-1:0]    out_id,
  output logic [OFF_W-1:0]   out_offset,
  output logic [LEN_W-1:0]   out_len,
  output logic               out_placed,
  output logic               out_last
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_REQ   = 2'd1;
  localparam logic [1:0] S_PLACE = 2'd2;

  logic [1:0]         state;
  logic               bank;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic [ID_W-1:0]    cur_seg;
  logic [ID_W-1:0]    next_seg;
  logic [SEG_W-1:0]   used;

  logic               batch_fits;
  logic [TOTAL_W:0]   batch_end;
  logic               batch_open;
  logic [LEN_W:0]     bs;
  logic [LEN_W-1:0]   mask;
  logic [LEN_W:0]     rnd_sum;
  logic [LEN_W-1:0]   aligned;
  logic [LEN_W-1:0]   eff;
  logic [SEG_W+1:0]   sum;
  logic               blk_open;
  logic [LEN_W-1:0]   used_raw;
  logic [SEG_W-1:0]   used_new;
  logic               slot_free;
  logic               emit;
  logic               item_last;

  assign slot_free = !out_valid || out_ready;
  assign desc_pop  = (state == S_IDLE) && desc_valid;
  assign emit      = (state == S_PLACE) && slot_free;
  assign item_last = (idx + CNT_W'(1) == count);
  assign release_valid = emit && item_last;
  assign release_bank  = bank;
  assign rd_addr       = {bank, idx[IW-1:0]};

  always_comb begin
    batch_fits = (desc.total != '0) && (desc.total <= TOTAL_W'(segment_bytes));
    batch_end  = {1'b0, desc.total} + (TOTAL_W+1)'(used);
    batch_open = (cur_seg == '0) ||
                 (batch_fits && (batch_end > (TOTAL_W+1)'(segment_bytes)));
  end

  // placement length from the registers in force when the batch is placed
  always_comb begin
    bs      = (LEN_W+1)'(1) << block_shift;
    mask    = LEN_W'(bs - (LEN_W+1)'(1));
    rnd_sum = {1'b0, rd_data.len} + {1'b0, mask};
    if (rd_data.len == '0) begin
      aligned = '0;
    end else if ({1'b0, rd_data.len} >= {2'b0, segment_bytes}) begin
      aligned = {1'b0, segment_bytes};
    end else begin
      aligned = rnd_sum[LEN_W-1:0] & ~mask;
    end
    // a zero segment size leaves the block at its raw length
    eff = (aligned == '0) ? rd_data.len : aligned;
  end

  always_comb begin
    sum      = (SEG_W+2)'(used) + (SEG_W+2)'(eff);
    blk_open = (cur_seg == '0) || (sum > (SEG_W+2)'(segment_bytes));
    used_raw = blk_open ? eff : sum[LEN_W-1:0];
    // used < 2^31 and eff may reach 2^32-1, so sum needs 33 bits
    if (!blk_open && sum[SEG_W+1]) begin
      used_new = USED_MAX;
    end else if (used_raw[LEN_W-1]) begin
      used_new = USED_MAX;
    end else begin
      used_new = used_raw[SEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur_seg   <= '0;
      next_seg  <= ID_W'(1);
      used      <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      out_valid <= emit || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (desc_valid) begin
            idx   <= '0;
            state <= S_REQ;
            if (batch_open) begin
              cur_seg <= next_seg;
              if (next_seg != ID_MAX) next_seg <= next_seg + ID_W'(1);
              used <= '0;
            end
          end
        end
        S_REQ: begin
          state <= S_PLACE;
        end
        S_PLACE: begin
          if (slot_free) begin
            if (rd_data.len != '0) begin
              used <= used_new;
              if (blk_open) begin
                cur_seg <= next_seg;
                if (next_seg != ID_MAX) next_seg <= next_seg + ID_W'(1);
              end
            end
            if (item_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + CNT_W'(1);
              state <= S_REQ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (desc_pop) begin
      bank  <= desc.bank;
      count <= desc.count;
    end
    if (emit) begin
      out_last <= rd_data.last;
      if (rd_data.len == '0) begin
        out_id     <= '0;
        out_offset <= '0;
        out_len    <= '0;
        out_placed <= 1'b0;
      end else begin
        out_id     <= blk_open ? next_seg : cur_seg;
        out_offset <= blk_open ? '0 : used[OFF_W-1:0];
        out_len    <= rd_data.len;
        out_placed <= 1'b1;
      end
    end
  end

endmodule

/* rtl/segment_landing_allocator_unit.sv */
// Segment landing allocator: places batches of blocks into log-structured
// segments and reports a landing location per block.
// Input stream (s_axis_*): one block length per transfer, tlast closes the
// batch. A batch is also closed after MAX_BATCH transfers.
// Output stream (m_axis_*): one result per block of a closed batch, in
// arrival order; tlast marks the block that carried the input tlast.
// Config port: cfg_we/cfg_index/cfg_data, index 0 = segment bytes,
// index 1 = block shift; a batch total uses the values at each transfer,
// placement uses the values in force when the batch is placed.
// Input side takes one transfer per cycle into a two-bank batch buffer; it
// stalls only when both banks hold batches not yet placed.
// The placement engine picks up each batch in its idle state, then per
// block reads the buffer and places it. With the engine idle, a closing
// transfer passes stage B and the descriptor queue before placement.
// A stall on m_axis holds the result register; the engine waits with the
// next block and the input side keeps filling the free bank.
// Reset (rst, synchronous) clears the config to its defaults, drops any
// held batch and results, closes the open segment and restarts ids at 1.
module segment_landing_allocator_unit
  import sla_pkg::*;
#(
  parameter int MAX_BATCH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // [31:0] block_length
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [47:0] segment_id, [77:48] segment_offset, [109:78] landing_length,
  // [110] placed, [111] zero
  output logic [111:0]         m_axis_tdata,
  output logic                 m_axis_tlast,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEG_W-1:0]     cfg_data
);

  localparam int IW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int AW = IW + 1;

  logic [SEG_W-1:0]   segment_bytes;
  logic [SHIFT_W-1:0] block_shift;

  logic               desc_push;
  batch_desc_t        push_desc;
  logic               desc_pop;
  logic               desc_valid;
  batch_desc_t        head_desc;
  logic               release_valid;
  logic               release_bank;
  logic [AW-1:0]      rd_addr;
  batch_entry_t       rd_data;

  logic [ID_W-1:0]    out_id;
  logic [OFF_W-1:0]   out_offset;
  logic [LEN_W-1:0]   out_len;
  logic               out_placed;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_bytes <= SEGMENT_BYTES_RST;
      block_shift   <= BLOCK_SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEGMENT_BYTES: segment_bytes <= cfg_data;
        REG_BLOCK_SHIFT:   block_shift   <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  sla_front #(.MAX_BATCH(MAX_BATCH)) u_front (
    .clk           (clk),
    .rst           (rst),
    .segment_bytes (segment_bytes),
    .block_shift   (block_shift),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_len        (s_axis_tdata),
    .in_last       (s_axis_tlast),
    .desc_push     (desc_push),
    .desc          (push_desc),
    .release_valid (release_valid),
    .release_bank  (release_bank),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data)
  );

  sla_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (desc_push),
    .push_desc (push_desc),
    .pop       (desc_pop),
    .nonempty  (desc_valid),
    .head      (head_desc)
  );

  sla_back #(.MAX_BATCH(MAX_BATCH)) u_back (
    .clk           (clk),
    .rst           (rst),
    .segment_bytes (segment_bytes),
    .block_shift   (block_shift),
    .desc_valid    (desc_valid),
    .desc          (head_desc),
    .desc_pop      (desc_pop),
    .release_valid (release_valid),
    .release_bank  (release_bank),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_id        (out_id),
    .out_offset    (out_offset),
    .out_len       (out_len),
    .out_placed    (out_placed),
    .out_last      (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_placed, out_len, out_offset, out_id};

endmodule

/* tb/sv/landing_book_pkg.sv */
`timescale 1ns / 1ps
package landing_book_pkg;
  import sla_pkg::*;

  typedef struct {
    logic [ID_W-1:0]  id;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic             placed;
    logic             last;
  } landing_t;

  // Mirrors the allocator: holds the open batch, places it on close and
  // queues one landing per held block.
  class landing_book;
    int unsigned        max_batch;
    logic [SEG_W-1:0]   seg_bytes;
    logic [SHIFT_W-1:0] shift;
    logic [LEN_W-1:0]   held_len[$];
    logic               held_last[$];
    logic [TOTAL_W-1:0] held_total;
    logic [ID_W-1:0]    cur_seg;
    logic [ID_W-1:0]    next_seg;
    logic [SEG_W-1:0]   used;
    landing_t           due[$];
    int errors;
    int n_blocks;
    int n_batches;
    int n_full;
    int n_placed;
    int n_skipped;
    int n_results;
    int n_writes;

    function new(int unsigned batch_limit);
      max_batch  = batch_limit;
      seg_bytes  = SEGMENT_BYTES_RST;
      shift      = BLOCK_SHIFT_RST;
      held_total = '0;
      cur_seg    = '0;
      next_seg   = 1;
      used       = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SEG_W-1:0] data);
      n_writes++;
      if (idx == REG_SEGMENT_BYTES) begin
        seg_bytes = data;
      end else if (idx == REG_BLOCK_SHIFT) begin
        shift = data[SHIFT_W-1:0];
      end
    endfunction

    function int pending();
      return due.size();
    endfunction

    // capped at the segment size, else rounded up to the block size
    function logic [63:0] rounded(logic [63:0] len);
      logic [63:0] bs;
      if (len == 0) return 0;
      if (len >= seg_bytes) return seg_bytes;
      bs = 64'd1 << shift;
      return (len + bs - 1) & ~(bs - 1);
    endfunction

    function void open_seg();
      cur_seg = next_seg;
      if (next_seg < ID_MAX) next_seg++;
      used = '0;
    endfunction

    function void make_room(logic [63:0] need);
      if (cur_seg == 0 || (need > 0 && used + need > seg_bytes)) open_seg();
    endfunction

    function void note_block(logic [LEN_W-1:0] len, logic last);
      logic [63:0] sum;
      logic [63:0] a;
      landing_t r;
      n_blocks++;
      held_len.push_back(len);
      held_last.push_back(last);
      sum = held_total + rounded(len);
      held_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      if (!last && held_len.size() < max_batch) return;

      n_batches++;
      if (!last) n_full++;
      // keep the batch together only when it fits in one segment
      if (held_total != 0 && held_total <= seg_bytes) begin
        make_room(held_total);
      end else if (cur_seg == 0) begin
        open_seg();
      end
      foreach (held_len[i]) begin
        r.last   = held_last[i];
        r.id     = '0;
        r.offset = '0;
        r.length = '0;
        r.placed = 1'b0;
        if (held_len[i] != 0) begin
          a = rounded(held_len[i]);
          if (a == 0) a = held_len[i];
          make_room(a);
          r.id     = cur_seg;
          r.offset = used[OFF_W-1:0];
          r.length = held_len[i];
          r.placed = 1'b1;
          sum = used + a;
          used = (sum > USED_MAX) ? USED_MAX : sum[SEG_W-1:0];
          n_placed++;
        end else begin
          n_skipped++;
        end
        due.push_back(r);
      end
      held_len.delete();
      held_last.delete();
      held_total = '0;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_landing(logic [111:0] data, logic last);
      landing_t w;
      if (due.size() == 0) begin
        $error("landing with no block waiting: data 0x%0h last %0b", data, last);
        errors++;
        return;
      end
      w = due.pop_front();
      n_results++;
      compare_field("segment_id", w.id, data[47:0]);
      compare_field("segment_offset", w.offset, data[77:48]);
      compare_field("landing_length", w.length, data[109:78]);
      compare_field("placed", w.placed, data[110]);
      compare_field("pad", 0, data[111]);
      compare_field("last_result", w.last, last);
    endfunction

    function void report();
      $display("covered %0d blocks in %0d batches, %0d of them closed at full size",
               n_blocks, n_batches, n_full);
      $display("%0d landings checked (%0d placed, %0d skipped), %0d register writes",
               n_results, n_placed, n_skipped, n_writes);
    endfunction
  endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import sla_pkg::*;
  import landing_book_pkg::*;

  localparam int          BATCH_MAX    = 64;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int          SETTLE       = 32;
  localparam int          N_PHASES     = 8;
  localparam int          PHASE_BLOCKS = 26;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;   // [31:0] block_length
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [47:0] segment_id, [77:48] segment_offset, [109:78] landing_length,
  // [110] placed, [111] zero
  logic [111:0]         m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SEG_W-1:0]     cfg_data = '0;

  int unsigned cycles = 0;
  int          src_gap_pct = 33;
  int          sink_idle_pct = 33;
  landing_book book;

  logic [SEG_W-1:0]   phase_seg[N_PHASES] = '{31'd4096, 31'h4000_0000, 31'd4194304,
                                              31'd0, 31'd5000, 31'h7FFF_FFFF,
                                              31'd4096, 31'd4096};
  logic [SHIFT_W-1:0] phase_shift[N_PHASES] = '{5'd9, 5'd16, 5'd12, 5'd0, 5'd12,
                                                5'd31, 5'd12, 5'd12};

  segment_landing_allocator_unit #(.MAX_BATCH(BATCH_MAX)) u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= (sink_idle_pct == 0) || ($urandom_range(99, 0) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) book.check_landing(m_axis_tdata, m_axis_tlast);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("segment_landing_allocator_unit regression: fail");
      $finish;
    end
  end

  task automatic send_block(input logic [31:0] len, input logic last);
    while (src_gap_pct != 0 && $urandom_range(99, 0) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= len;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    book.note_block(len, last);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    book.set_reg(idx, data);
  endtask

  // spare index first: the block must ignore it
  task automatic apply_config(input logic [SEG_W-1:0] seg, input logic [SHIFT_W-1:0] sh);
    logic [SEG_W-1:0] shift_word;
    shift_word = SEG_W'(($urandom() & ~32'h1F) | sh);
    write_reg($urandom_range(1, 0) ? REG_SPARE_HI : REG_SPARE_LO, SEG_W'($urandom()));
    write_reg(REG_SEGMENT_BYTES, seg);
    write_reg(REG_BLOCK_SHIFT, shift_word);
    cfg_we <= 1'b0;
  endtask

  // hold off until every landing is back, then let the engine go quiet
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_length();
    logic [31:0] span;
    logic [31:0] len;
    span = (book.seg_bytes < 31'd4096) ? 32'd4096 : {1'b0, book.seg_bytes};
    case ($urandom_range(9, 0))
      0:       len = '0;
      1:       len = $urandom();
      2:       len = span + $urandom_range(1, 0);
      3:       len = $urandom_range(8, 1) << book.shift;
      4:       len = $urandom_range(64, 1);
      default: len = $urandom_range(span / 4, 1);
    endcase
    return len;
  endfunction

  task automatic send_batch(input int unsigned n_items);
    for (int unsigned i = 1; i <= n_items; i++) send_block(pick_length(), i == n_items);
  endtask

  initial begin
    int sent;
    int n;
    book = new(BATCH_MAX);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: single block, edge lengths, all-zero batch, oversized batch
    send_block(32'd1, 1'b1);
    send_block(32'd4096, 1'b0);
    send_block(32'd4097, 1'b0);
    send_block(32'hFFFF_FFFF, 1'b0);
    send_block(32'd0, 1'b0);
    send_block(32'd4095, 1'b1);
    send_block(32'd0, 1'b0);
    send_block(32'd0, 1'b0);
    send_block(32'd0, 1'b1);
    send_block(32'd2097152, 1'b0);
    send_block(32'd2097152, 1'b0);
    send_block(32'd2097152, 1'b1);
    send_block(32'd1, 1'b1);
    // registers change while a batch is half loaded
    send_block(32'h0000_0FFF, 1'b0);
    send_block(32'h8000_0000, 1'b0);
    drain_and_settle();
    apply_config(31'd4096, 5'd9);
    send_block(32'd5000, 1'b1);
    send_block(32'd0, 1'b1);

    phase_seg[6]   = SEG_W'($urandom_range(32'h4000_0000, 4096));
    phase_shift[6] = SHIFT_W'($urandom_range(16, 9));
    phase_seg[7]   = SEG_W'($urandom());
    phase_shift[7] = SHIFT_W'($urandom());

    for (int p = 0; p < N_PHASES; p++) begin
      drain_and_settle();
      apply_config(phase_seg[p], phase_shift[p]);
      src_gap_pct   = (p == 2) ? 0 : 33;
      sink_idle_pct = (p == 2) ? 0 : 33;
      if (p == 2) begin
        // one batch closed by its size, then one exactly full with a last flag
        send_batch(70);
        send_batch(BATCH_MAX);
      end else begin
        sent = 0;
        while (sent < PHASE_BLOCKS) begin
          n = ($urandom_range(4, 0) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
          send_batch(n);
          sent += n;
        end
        // sometimes leave a batch open across the register change
        if ($urandom_range(1, 0)) send_block(pick_length(), 1'b0);
      end
    end
    send_block(pick_length(), 1'b1);
    drain_and_settle();

    book.report();
    if (book.errors == 0 && book.pending() == 0) begin
      $display("segment_landing_allocator_unit regression: pass");
    end else begin
      $display("segment_landing_allocator_unit regression: fail");
    end
    $finish;
  end

endmodule

/* segment_landing_allocator_unit.f */
rtl/sla_pkg.sv
rtl/sla_front.sv
rtl/sla_queue.sv
rtl/sla_back.sv
rtl/segment_landing_allocator_unit.sv
tb/sv/landing_book_pkg.sv
tb/sv/tb_top.sv
